[src/rau_pkg.sv]
// -----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes of the rational arithmetic unit.
// -----------------------------------------------------------------------------
package rau_pkg;

   // operation codes
   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_SUB = 2'd1;
   localparam logic [1:0] ACT_MUL = 2'd2;
   localparam logic [1:0] ACT_DIV = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DIVZ  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NOP     = 4'd0,
      CMD_LOAD    = 4'd1,  // capture operands, decode signs
      CMD_GCD_LD  = 4'd2,  // load gcd unit with two operands (sel by src)
      CMD_GCD_STP = 4'd3,  // one gcd step
      CMD_DIV_LD  = 4'd4,  // load divider
      CMD_DIV_STP = 4'd5,  // one divider step
      CMD_MUL_LD  = 4'd6,  // load multiplier
      CMD_MUL_STP = 4'd7,  // one multiplier step
      CMD_STORE   = 4'd8,  // move unit result to a holding register
      CMD_COMBINE = 4'd9,  // signed add of cross products
      CMD_FINISH  = 4'd10  // range check and result capture
   } cmd_type;

   // operand / destination selectors
   typedef enum logic [3:0] {
      R_D1, R_D2, R_M1, R_M2, R_G, R_A, R_B, R_NUM, R_DEN, R_Q1, R_Q2
   } reg_sel_type;

   typedef struct packed {
      cmd_type     cmd;
      reg_sel_type src_a;
      reg_sel_type src_b;
      reg_sel_type dst;
   } dp_ctrl_type;

   typedef struct packed {
      logic       unit_done;  // current iterative unit has finished
      logic       bad_in;     // zero denominator or zero divisor
      logic [1:0] action;
      logic       num_zero;   // combined numerator is zero
   } dp_stat_type;

endpackage

[src/rau_datapath.sv]
// -----------------------------------------------------------------------------
// rau_datapath
// Register file, shift-add multiplier, binary gcd and restoring divider,
// each advanced one step per cycle under command of the controller.
// -----------------------------------------------------------------------------
module rau_datapath #(
   parameter int W = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_action,
   input  logic [W-1:0]         req_left_numerator,
   input  logic [W-1:0]         req_left_denominator,
   input  logic [W-1:0]         req_right_numerator,
   input  logic [W-1:0]         req_right_denominator,
   input  rau_pkg::dp_ctrl_type ctrl,
   output rau_pkg::dp_stat_type stat,
   output logic [W-1:0]         res_num,
   output logic [W-1:0]         res_den,
   output logic [1:0]           res_status
);
   import rau_pkg::*;

   localparam int WW  = 2 * W;          // exact intermediate width
   localparam int CW  = $clog2(WW + 1); // step counters

   logic [1:0]    act_ff;
   logic          s1_ff, s2_ff, rs_ff;
   logic [WW-1:0] rf_ff [11];

   // multiplier
   logic [WW-1:0] mul_acc_ff, mul_a_ff;
   logic [W-1:0]  mul_b_ff;
   // gcd
   logic [WW-1:0] ga_ff, gb_ff;
   logic [CW-1:0] gk_ff;
   logic [1:0]    gph_ff;
   // divider
   logic [WW-1:0] dq_ff, dr_ff, dd_ff;
   logic [CW-1:0] cnt_ff;
   logic          carry;
   logic [WW:0]   dr_sh, dr_diff;

   logic [WW-1:0] op_a, op_b, unit_res;
   logic [W-1:0]  ln, rn, m1, m2;

   assign op_a = rf_ff[ctrl.src_a];
   assign op_b = rf_ff[ctrl.src_b];
   assign ln   = req_left_numerator;
   assign rn   = req_right_numerator;
   assign m1   = ln[W-1] ? W'(-ln) : ln;
   assign m2   = rn[W-1] ? W'(-rn) : rn;

   assign dr_sh   = {dr_ff, dq_ff[WW-1]};
   assign carry   = dr_sh[WW];
   assign dr_diff = dr_sh - {1'b0, dd_ff};

   // unit result for store
   always_comb begin
      unique case (ctrl.src_b)
         R_Q1:    unit_res = mul_acc_ff;
         R_Q2:    unit_res = dq_ff;
         default: unit_res = ga_ff << gk_ff;
      endcase
   end

   // status back to controller
   always_comb begin
      stat.action   = act_ff;
      stat.bad_in   = (rf_ff[R_D1] == '0) || (rf_ff[R_D2] == '0)
                      || (act_ff == ACT_DIV && rf_ff[R_M2] == '0);
      stat.num_zero = (rf_ff[R_NUM] == '0);
      unique case (ctrl.cmd)
         CMD_GCD_STP: stat.unit_done = (gph_ff == 2'd2) && (gb_ff == '0);
         CMD_DIV_STP,
         CMD_MUL_STP: stat.unit_done = (cnt_ff == '0);
         default:     stat.unit_done = 1'b0;
      endcase
   end

   // main datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         unique case (ctrl.cmd)
            CMD_LOAD: begin
               act_ff     <= req_action;
               s1_ff      <= ln[W-1];
               s2_ff      <= (req_action == ACT_SUB) ? ~rn[W-1] : rn[W-1];
               // product sign; add/subtract replaces it on combine
               rs_ff      <= ln[W-1] ^ rn[W-1];
               rf_ff[R_D1] <= WW'(req_left_denominator);
               rf_ff[R_D2] <= WW'(req_right_denominator);
               rf_ff[R_M1] <= WW'(m1);
               rf_ff[R_M2] <= WW'(m2);
            end
            CMD_MUL_LD: begin
               mul_acc_ff <= '0;
               mul_a_ff   <= op_a;
               mul_b_ff   <= op_b[W-1:0];
               cnt_ff     <= CW'(W);
            end
            CMD_MUL_STP: begin
               if (cnt_ff != '0) begin
                  if (mul_b_ff[0]) mul_acc_ff <= mul_acc_ff + mul_a_ff;
                  mul_a_ff <= mul_a_ff << 1;
                  mul_b_ff <= mul_b_ff >> 1;
                  cnt_ff   <= cnt_ff - 1'b1;
               end
            end
            CMD_GCD_LD: begin
               ga_ff  <= op_a;
               gb_ff  <= op_b;
               gk_ff  <= '0;
               gph_ff <= 2'd0;
            end
            CMD_GCD_STP: begin
               unique case (gph_ff)
                  2'd0: begin
                     if (!ga_ff[0] && !gb_ff[0]) begin
                        ga_ff <= ga_ff >> 1;
                        gb_ff <= gb_ff >> 1;
                        gk_ff <= gk_ff + 1'b1;
                     end else gph_ff <= 2'd1;
                  end
                  2'd1: begin
                     if (!ga_ff[0]) ga_ff <= ga_ff >> 1;
                     else gph_ff <= 2'd2;
                  end
                  default: begin
                     if (gb_ff != '0) begin
                        if (!gb_ff[0]) gb_ff <= gb_ff >> 1;
                        else if (ga_ff > gb_ff) begin
                           ga_ff <= gb_ff;
                           gb_ff <= ga_ff - gb_ff;
                        end else gb_ff <= gb_ff - ga_ff;
                     end
                  end
               endcase
            end
            CMD_DIV_LD: begin
               dq_ff  <= op_a;
               dd_ff  <= op_b;
               dr_ff  <= '0;
               cnt_ff <= CW'(WW);
            end
            CMD_DIV_STP: begin
               if (cnt_ff != '0) begin
                  if (carry || !dr_diff[WW]) begin
                     dr_ff <= dr_diff[WW-1:0];
                     dq_ff <= {dq_ff[WW-2:0], 1'b1};
                  end else begin
                     dr_ff <= dr_sh[WW-1:0];
                     dq_ff <= {dq_ff[WW-2:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            CMD_STORE: rf_ff[ctrl.dst] <= unit_res;
            CMD_COMBINE: begin
               if (s1_ff == s2_ff) begin
                  rf_ff[R_NUM] <= op_a + op_b;
                  rs_ff        <= s1_ff;
               end else if (op_a >= op_b) begin
                  rf_ff[R_NUM] <= op_a - op_b;
                  rs_ff        <= s1_ff;
               end else begin
                  rf_ff[R_NUM] <= op_b - op_a;
                  rs_ff        <= s2_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // final formatting from reduced numerator (R_Q1) and denominator (R_Q2)
   logic [WW-1:0] lim;
   logic          ovf;
   assign lim = rs_ff ? (WW'(1) << (W-1)) : ((WW'(1) << (W-1)) - 1'b1);
   assign ovf = (rf_ff[R_Q1] > lim) || (rf_ff[R_Q2][WW-1:W] != '0);
   always_comb begin
      if (stat.bad_in) begin
         res_num = '0; res_den = W'(1); res_status = ST_DIVZ;
      end else if (stat.num_zero) begin
         res_num = '0; res_den = W'(1); res_status = ST_OK;
      end else if (ovf) begin
         res_num = '0; res_den = W'(1); res_status = ST_RANGE;
      end else begin
         res_num    = rs_ff ? W'(-rf_ff[R_Q1]) : rf_ff[R_Q1][W-1:0];
         res_den    = rf_ff[R_Q2][W-1:0];
         res_status = ST_OK;
      end
   end

endmodule

[src/rau_ctrl.sv]
// -----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: runs a micro-program of unit loads, steps and stores.
// -----------------------------------------------------------------------------
module rau_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rau_pkg::dp_stat_type stat,
   output rau_pkg::dp_ctrl_type ctrl,
   output logic                 capture
);
   import rau_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RUN  = 4'b0010,
      S_WAIT = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] pc_ff, pc_in;
   logic       rv_ff, rv_in;
   dp_ctrl_type u;
   logic        is_step;

   // micro-program: add/sub from 0, mul/div from 30, reduce from 20
   always_comb begin
      u = '{CMD_NOP, R_D1, R_D1, R_D1};
      unique case (pc_ff)
         5'd0:  u = '{CMD_GCD_LD,  R_D1, R_D2, R_D1};
         5'd1:  u = '{CMD_GCD_STP, R_D1, R_D1, R_D1};
         5'd2:  u = '{CMD_STORE,   R_D1, R_G,  R_G};
         5'd3:  u = '{CMD_DIV_LD,  R_D2, R_G,  R_D1};
         5'd4:  u = '{CMD_DIV_STP, R_D1, R_D1, R_D1};
         5'd5:  u = '{CMD_STORE,   R_D1, R_Q2, R_A};   // d2/g
         5'd6:  u = '{CMD_DIV_LD,  R_D1, R_G,  R_D1};
         5'd7:  u = '{CMD_DIV_STP, R_D1, R_D1, R_D1};
         5'd8:  u = '{CMD_STORE,   R_D1, R_Q2, R_B};   // d1/g
         5'd9:  u = '{CMD_MUL_LD,  R_M1, R_A,  R_D1};
         5'd10: u = '{CMD_MUL_STP, R_D1, R_D1, R_D1};
         5'd11: u = '{CMD_STORE,   R_D1, R_Q1, R_A};
         5'd12: u = '{CMD_MUL_LD,  R_M2, R_B,  R_D1};
         5'd13: u = '{CMD_MUL_STP, R_D1, R_D1, R_D1};
         5'd14: u = '{CMD_STORE,   R_D1, R_Q1, R_NUM};
         5'd15: u = '{CMD_COMBINE, R_A,  R_NUM, R_D1};
         5'd16: u = '{CMD_MUL_LD,  R_B,  R_D2, R_D1};
         5'd17: u = '{CMD_MUL_STP, R_D1, R_D1, R_D1};
         5'd18: u = '{CMD_STORE,   R_D1, R_Q1, R_DEN};
         5'd19: u = '{CMD_NOP,     R_D1, R_D1, R_D1};
         5'd20: u = '{CMD_GCD_LD,  R_NUM, R_DEN, R_D1};
         5'd21: u = '{CMD_GCD_STP, R_D1, R_D1, R_D1};
         5'd22: u = '{CMD_STORE,   R_D1, R_G,  R_G};
         5'd23: u = '{CMD_DIV_LD,  R_NUM, R_G, R_D1};
         5'd24: u = '{CMD_DIV_STP, R_D1, R_D1, R_D1};
         5'd25: u = '{CMD_STORE,   R_D1, R_Q2, R_Q1};
         5'd26: u = '{CMD_DIV_LD,  R_DEN, R_G, R_D1};
         5'd27: u = '{CMD_DIV_STP, R_D1, R_D1, R_D1};
         5'd28: u = '{CMD_STORE,   R_D1, R_Q2, R_Q2};
         5'd29: u = '{CMD_FINISH,  R_D1, R_D1, R_D1};
         5'd30: u = '{CMD_MUL_LD,  R_M1, R_D2, R_D1};  // mul: m1*d2 or m1*m2
         5'd31: u = '{CMD_MUL_STP, R_D1, R_D1, R_D1};
         default: ;
      endcase
   end

   assign is_step = (u.cmd == CMD_GCD_STP) || (u.cmd == CMD_DIV_STP)
                    || (u.cmd == CMD_MUL_STP);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;

   // drive datapath; the load beat itself is issued in idle
   always_comb begin
      ctrl    = '{CMD_NOP, R_D1, R_D1, R_D1};
      capture = 1'b0;
      if (state_ff == S_IDLE && req_valid) ctrl.cmd = CMD_LOAD;
      else if (state_ff == S_RUN) begin
         ctrl = u;
         // multiply/divide cross products, re-using rows 30..31, 14 and 16..18
         if (pc_ff == 5'd30) begin
            if (stat.action == ACT_MUL) ctrl.src_b = R_M2;
            else ctrl.src_b = R_D2;
         end
         if (pc_ff == 5'd16 && stat.action[1]) begin
            ctrl.src_a = R_D1;
            ctrl.src_b = (stat.action == ACT_MUL) ? R_D2 : R_M2;
         end
         if (pc_ff == 5'd29) capture = 1'b1;
      end
   end

   // sequencing
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      rv_in    = rv_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // decoded operands available: pick program
            state_in = S_RUN;
            if (stat.bad_in) begin
               pc_in = 5'd29;
            end else if (stat.action[1]) begin
               pc_in = 5'd30;
            end else begin
               pc_in = 5'd0;
            end
         end
         S_RUN: begin
            if (is_step && !stat.unit_done) pc_in = pc_ff;
            else if (pc_ff == 5'd29) begin
               state_in = S_OUT;
               rv_in    = 1'b1;
            end else if (stat.bad_in) pc_in = 5'd29;
            else if (pc_ff == 5'd31) pc_in = 5'd14;
            else if (pc_ff == 5'd14 && stat.action[1]) pc_in = 5'd16;
            else if (pc_ff == 5'd19) pc_in = stat.num_zero ? 5'd29 : 5'd20;
            else pc_in = pc_ff + 1'b1;
         end
         S_OUT: begin
            if (rv_ff && rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff    <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         rv_ff    <= rv_in;
      end
   end

`ifndef SYNTHESIS
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_rv_out: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> state_ff == S_OUT) else $error("result beat outside output state");
   a_no_acc: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !req_ready) else $error("accepting while result pending");
`endif

endmodule

[src/rational_arithmetic_unit_top.sv]
// -----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Exact add, subtract, multiply and divide on fractions, gcd-reduced.
// -----------------------------------------------------------------------------
// One item at a time: the next request beat is taken only after the result
// beat has gone. Exact divisions are bit-serial, multiplies are shift-add and
// the gcd is binary. Multiply/divide: two multiplies, one gcd of the 2W-bit
// result and two divisions. Add/subtract: one gcd of the denominators, two
// divisions and three multiplies, then the same reduction. A zero denominator
// or a zero divisor gives status 1 and 0/1; an unrepresentable reduced result
// gives status 2 and 0/1.
module rational_arithmetic_unit_top #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_action,
   input  logic [OPERAND_WIDTH-1:0] req_left_numerator,
   input  logic [OPERAND_WIDTH-1:0] req_left_denominator,
   input  logic [OPERAND_WIDTH-1:0] req_right_numerator,
   input  logic [OPERAND_WIDTH-1:0] req_right_denominator,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [OPERAND_WIDTH-1:0] rsp_result_numerator,
   output logic [OPERAND_WIDTH-1:0] rsp_result_denominator,
   output logic [1:0]               rsp_status
);
   import rau_pkg::*;

   dp_ctrl_type ctrl;
   dp_stat_type stat;
   logic        capture;
   logic [OPERAND_WIDTH-1:0] rn, rd;
   logic [1:0]  rst_code;
   logic [OPERAND_WIDTH-1:0] num_ff, den_ff;
   logic [1:0]  st_ff;

   rau_datapath #(.W(OPERAND_WIDTH)) u_dp (
      .clock, .reset, .req_action, .req_left_numerator, .req_left_denominator,
      .req_right_numerator, .req_right_denominator, .ctrl, .stat,
      .res_num(rn), .res_den(rd), .res_status(rst_code)
   );

   rau_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .ctrl, .capture
   );

   // output register, loaded on the finishing step
   always_ff @(posedge clock) begin
      if (capture) begin
         num_ff <= rn;
         den_ff <= rd;
         st_ff  <= rst_code;
      end
   end

   assign rsp_result_numerator   = num_ff;
   assign rsp_result_denominator = den_ff;
   assign rsp_status             = st_ff;

endmodule

[sim/rational_arithmetic_unit_top_tb.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// rational_arithmetic_unit_top_tb
// Self-checking bench for the fraction add/subtract/multiply/divide unit.
// A directed set of corner beats is followed by random beats. The sender
// works in bursts and the receiver stalls on its own pattern. Every accepted
// request is predicted with exact 128-bit arithmetic. Each response beat is
// checked field by field against the oldest prediction.
// -----------------------------------------------------------------------------
module rational_arithmetic_unit_top_tb;
   import rau_pkg::*;

   localparam int W         = 32;
   localparam int N_RANDOM  = 1700;
   localparam int MAX_CYCLE = 20000000;

   typedef struct {
      logic [1:0]   action;
      logic [W-1:0] ln, ld, rn, rd;
   } fraction_op_type;

   typedef struct {
      logic [W-1:0] num, den;
      logic [1:0]   status;
   } fraction_res_type;

   logic clock = 1'b0, reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   logic [1:0] req_action = ACT_ADD;
   logic [W-1:0] req_left_numerator = '0, req_left_denominator = 1;
   logic [W-1:0] req_right_numerator = '0, req_right_denominator = 1;
   logic rsp_valid, rsp_ready = 1'b0;
   logic [W-1:0] rsp_result_numerator, rsp_result_denominator;
   logic [1:0] rsp_status;

   fraction_op_type  op_queue[$];
   fraction_res_type answer_queue[$];
   logic req_taken = 1'b0;
   int   gap_left = 0, burst_left = 1, cycle_count = 0, error_count = 0;
   int   stall_mode = 0;

   rational_arithmetic_unit_top #(.OPERAND_WIDTH(W)) dut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Euclid on wide magnitudes; both nonzero
   function automatic logic [127:0] wide_gcd(logic [127:0] a, logic [127:0] b);
      logic [127:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // expected response of one request
   function automatic fraction_res_type reduce_fraction(fraction_op_type op);
      fraction_res_type r;
      logic          s1, s2, sb, rs;
      logic [127:0]  m1, m2, d1, d2, g, a, b, num, den;
      r.num = '0;
      r.den = 1;
      r.status = ST_OK;
      s1 = op.ln[W-1];
      s2 = op.rn[W-1];
      // magnitudes taken at operand width, then widened
      m1 = s1 ? 128'(W'(-op.ln)) : 128'(op.ln);
      m2 = s2 ? 128'(W'(-op.rn)) : 128'(op.rn);
      d1 = 128'(op.ld);
      d2 = 128'(op.rd);
      if (d1 == 0 || d2 == 0 || (op.action == ACT_DIV && m2 == 0)) begin
         r.status = ST_DIVZ;
         return r;
      end
      case (op.action)
         ACT_ADD, ACT_SUB: begin
            g   = wide_gcd(d1, d2);
            a   = m1 * (d2 / g);
            b   = m2 * (d1 / g);
            den = (d1 / g) * d2;
            sb  = (op.action == ACT_SUB) ? !s2 : s2;
            if (s1 == sb) begin
               num = a + b;
               rs  = s1;
            end else if (a >= b) begin
               num = a - b;
               rs  = s1;
            end else begin
               num = b - a;
               rs  = sb;
            end
         end
         ACT_MUL: begin
            num = m1 * m2;
            den = d1 * d2;
            rs  = s1 ^ s2;
         end
         default: begin
            num = m1 * d2;
            den = d1 * m2;
            rs  = s1 ^ s2;
         end
      endcase
      if (num == 0) return r;
      g   = wide_gcd(num, den);
      num = num / g;
      den = den / g;
      if (num > (rs ? 128'h8000_0000 : 128'h7fff_ffff) || den > 128'hffff_ffff) begin
         r.status = ST_RANGE;
         return r;
      end
      r.num = rs ? W'(-num) : W'(num);
      r.den = W'(den);
      return r;
   endfunction

   function automatic logic [W-1:0] rand_den(bit tiny);
      logic [W-1:0] v;
      v = tiny ? W'($urandom_range(1, 40)) : W'($urandom);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic logic [W-1:0] rand_num(bit tiny);
      return tiny ? W'($urandom_range(0, 80)) - W'(40) : W'($urandom);
   endfunction

   task automatic add_op(logic [1:0] act, logic [W-1:0] ln, ld, rn, rd);
      fraction_op_type op;
      op.action = act;
      op.ln = ln; op.ld = ld; op.rn = rn; op.rd = rd;
      op_queue.push_back(op);
   endtask

   // request driver: bursts with gaps, changes at the falling edge
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_left > 0 || op_queue.size() == 0) begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else begin
            fraction_op_type op;
            op = op_queue.pop_front();
            req_action            <= op.action;
            req_left_numerator    <= op.ln;
            req_left_denominator  <= op.ld;
            req_right_numerator   <= op.rn;
            req_right_denominator <= op.rd;
            req_valid             <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 8);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // response stall pattern: free-running, light and heavy phases
   always @(negedge clock) begin
      if (cycle_count % 512 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // request beat capture and prediction
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         fraction_op_type op;
         op.action = req_action;
         op.ln = req_left_numerator;  op.ld = req_left_denominator;
         op.rn = req_right_numerator; op.rd = req_right_denominator;
         answer_queue.push_back(reduce_fraction(op));
      end
   end

   // response beat check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (answer_queue.size() == 0) begin
            $error("unexpected response beat");
            error_count++;
         end else begin
            fraction_res_type e;
            e = answer_queue.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_status);
               error_count++;
            end
            if (rsp_result_numerator !== e.num) begin
               $error("result_numerator: expected %0d, actual %0d",
                      $signed(e.num), $signed(rsp_result_numerator));
               error_count++;
            end
            if (rsp_result_denominator !== e.den) begin
               $error("result_denominator: expected %0d, actual %0d",
                      e.den, rsp_result_denominator);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count >= MAX_CYCLE) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      logic [W-1:0] minv, maxv, maxd;
      bit tiny;
      minv = {1'b1, {(W-1){1'b0}}};
      maxv = {1'b0, {(W-1){1'b1}}};
      maxd = '1;
      // directed corners
      add_op(ACT_ADD, 1, 2, 1, 3);
      add_op(ACT_ADD, 1, 2, -1, 2);            // zero result
      add_op(ACT_SUB, 3, 4, 3, 4);
      add_op(ACT_SUB, -5, 6, 7, 10);
      add_op(ACT_MUL, 6, 35, 14, 9);
      add_op(ACT_DIV, 3, 7, -9, 14);           // negative divisor
      add_op(ACT_DIV, 5, 3, 0, 7);             // divide by zero
      add_op(ACT_MUL, maxv, 1, maxv, 1);       // out of range
      add_op(ACT_MUL, minv, 1, 1, 1);
      add_op(ACT_MUL, minv, 1, -1, 1);         // +2^31 overflows
      add_op(ACT_DIV, minv, 1, -1, 1);
      add_op(ACT_ADD, maxv, maxd, maxv, maxd);
      add_op(ACT_SUB, minv, maxd, maxv, 1);
      add_op(ACT_ADD, minv, 1, minv, 1);
      add_op(ACT_MUL, 1, maxd, 1, maxd);       // denominator too wide
      add_op(ACT_DIV, maxv, maxd, minv, maxd);
      add_op(ACT_ADD, 0, maxd, 0, 1);
      add_op(ACT_SUB, maxv, 1, minv, 1);
      add_op(ACT_DIV, -1, 1, maxv, 1);
      add_op(ACT_MUL, 0, 5, minv, 3);
      // random part: mostly small operands so that reduction matters
      for (int i = 0; i < N_RANDOM; i++) begin
         tiny = ($urandom_range(0, 2) != 0);
         add_op(2'($urandom), rand_num(tiny), rand_den(tiny),
                rand_num($urandom_range(0, 2) != 0), rand_den($urandom_range(0, 2) != 0));
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (op_queue.size() == 0 && !req_valid);
      wait (answer_queue.size() == 0);
      repeat (600) @(posedge clock);
      if (error_count == 0 && answer_queue.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[filelist.f]
src/rau_pkg.sv
src/rau_datapath.sv
src/rau_ctrl.sv
src/rational_arithmetic_unit_top.sv
sim/rational_arithmetic_unit_top_tb.sv
